// ----- rtl/core/imuc_pkg.sv -----
// Shared types and constants for the IMU raw-to-units converter.
// No dependencies; imported by every module of the block.
package imuc_pkg;

  // Pipeline depth: input register through output register
  localparam int NSTAGE = 5;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int MAG_W   = 16;
  localparam int ACC_W   = 15;
  localparam int RATE_W  = 19;
  localparam int CFG_W   = 3;

  // Accel: mg = floor((|raw|*scale + 500) / 1000), via reciprocal multiply
  localparam int ACC_SCL_W = 9;
  localparam int ACC_P0_W  = 24;
  localparam int ACC_M1_W  = 29;
  localparam int ACC_P1_W  = ACC_P0_W + ACC_M1_W;
  localparam int ACC_SH1   = 38;
  localparam logic [ACC_M1_W-1:0] ACC_M1 = 29'd274877907;
  localparam logic [ACC_P0_W-1:0] ACC_RND1 = 24'd500;
  localparam int MG_W = 14;

  // Accel: cms2 = mg - floor((mg*19335 + 499999) / 1000000)
  // (mg*980665 = mg*1e6 - mg*19335, rounded half away from zero)
  localparam int ACC_U_W  = 29;
  localparam int ACC_M2_W = 30;
  localparam int ACC_P2_W = ACC_U_W + ACC_M2_W;
  localparam int ACC_SH2  = 49;
  localparam int ACC_CORR_W = ACC_P2_W - ACC_SH2;
  localparam logic [ACC_M2_W-1:0] ACC_M2 = 30'd562949954;
  localparam logic [14:0] ACC_FRAC = 15'd19335;
  localparam logic [ACC_U_W-1:0] ACC_RND2 = 29'd499999;

  // Rate: (|raw|*100000 + div/2) >> log2(div)
  localparam int RATE_P_W = 33;
  localparam int RATE_MAG_W = 18;
  localparam logic [16:0] RATE_MUL = 17'd100000;
  localparam int SH_W = 5;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ACCEL_RANGE = 1'b0,
    CFG_GYRO_RANGE  = 1'b1
  } cfg_idx_t;

  // Stage load enables from the pipeline control to the lanes
  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } imuc_ctl_t;

  // Accel range code to thousandths of mg per LSB
  function automatic logic [ACC_SCL_W-1:0] acc_scale(input logic [1:0] code);
    logic [ACC_SCL_W-1:0] s;
    case (code)
      2'd0:    s = 9'd61;
      2'd1:    s = 9'd122;
      2'd2:    s = 9'd244;
      default: s = 9'd488;
    endcase
    return s;
  endfunction

  // Gyro range code to log2 of (LSB per dps * 1000); unused codes act as 500 dps
  function automatic logic [SH_W-1:0] gyr_shift(input logic [2:0] code);
    logic [SH_W-1:0] s;
    case (code)
      3'd0:    s = 5'd14;
      3'd1:    s = 5'd15;
      3'd2:    s = 5'd16;
      3'd3:    s = 5'd17;
      3'd4:    s = 5'd18;
      default: s = 5'd16;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/imuc_pipe_ctrl.sv -----
// Valid tracking and per-stage load enables for the converter pipeline.
// Depends on imuc_pkg. Bubbles collapse, so a waiting output does not stall empty stages.
module imuc_pipe_ctrl import imuc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output imuc_ctl_t ctl
);

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] load;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    load[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      load[i] = !vld_r[i] || load[i+1];
    end
  end

  // Valid bits follow the beats
  always_comb begin
    vld_nxt = vld_r;
    if (load[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (load[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.load  = load;
  assign in_stall  = !load[0];
  assign out_valid = vld_r[NSTAGE-1];

endmodule

// ----- rtl/core/imuc_accel_lane.sv -----
// One accelerometer axis: raw count to hundredths of m/s^2 in five stages.
// Depends on imuc_pkg; stage enables come from imuc_pipe_ctrl.
module imuc_accel_lane import imuc_pkg::*; (
  input  logic                    clk,
  input  imuc_ctl_t               ctl,
  input  logic [1:0]              accel_range,
  input  logic signed [RAW_W-1:0] raw,
  output logic signed [ACC_W-1:0] result
);

  logic [NSTAGE-2:0]     neg_r;
  logic [MAG_W-1:0]      mag;
  logic [ACC_P0_W-1:0]   p0_r;
  logic [ACC_P1_W-1:0]   p1_r;
  logic [MG_W-1:0]       mg_nxt;
  logic [MG_W-1:0]       mg2_r;
  logic [MG_W-1:0]       mg3_r;
  logic [ACC_U_W-1:0]    u_r;
  logic [ACC_P2_W-1:0]   p2_r;
  logic [MG_W-1:0]       q_nxt;
  logic signed [ACC_W-1:0] result_r;

  // Magnitude of the raw count; -32768 maps to 32768
  assign mag = raw[RAW_W-1] ? MAG_W'(-raw) : MAG_W'(raw);

  // Integer mg after the rounded /1000, and cm/s^2 after the correction
  assign mg_nxt = p1_r[ACC_SH1 +: MG_W];
  assign q_nxt  = mg3_r - MG_W'(p2_r[ACC_SH2 +: ACC_CORR_W]);

  always_ff @(posedge clk) begin
    // stage 0: scale product
    if (ctl.load[0]) begin
      p0_r     <= ACC_P0_W'(mag) * ACC_P0_W'(acc_scale(accel_range));
      neg_r[0] <= raw[RAW_W-1];
    end
    // stage 1: round and multiply by the reciprocal of 1000
    if (ctl.load[1]) begin
      p1_r     <= ACC_P1_W'(p0_r + ACC_RND1) * ACC_P1_W'(ACC_M1);
      neg_r[1] <= neg_r[0];
    end
    // stage 2: mg, and the g-to-m/s^2 correction term
    if (ctl.load[2]) begin
      mg2_r    <= mg_nxt;
      u_r      <= ACC_U_W'(mg_nxt) * ACC_U_W'(ACC_FRAC) + ACC_RND2;
      neg_r[2] <= neg_r[1];
    end
    // stage 3: correction divided by 1e6 via reciprocal
    if (ctl.load[3]) begin
      mg3_r    <= mg2_r;
      p2_r     <= ACC_P2_W'(u_r) * ACC_P2_W'(ACC_M2);
      neg_r[3] <= neg_r[2];
    end
    // stage 4: apply correction and sign
    if (ctl.load[4]) begin
      result_r <= neg_r[3] ? -$signed(ACC_W'(q_nxt)) : $signed(ACC_W'(q_nxt));
    end
  end

  assign result = result_r;

endmodule

// ----- rtl/core/imuc_rate_lane.sv -----
// One gyroscope axis: raw count to hundredths of deg/s, matched to the accel latency.
// Depends on imuc_pkg; stage enables come from imuc_pipe_ctrl.
module imuc_rate_lane import imuc_pkg::*; (
  input  logic                     clk,
  input  imuc_ctl_t                ctl,
  input  logic [2:0]               gyro_range,
  input  logic signed [RAW_W-1:0]  raw,
  output logic signed [RATE_W-1:0] result
);

  logic [NSTAGE-2:0]      neg_r;
  logic [MAG_W-1:0]       mag;
  logic [RATE_P_W-1:0]    p0_r;
  logic [SH_W-1:0]        sh;
  logic [RATE_P_W-1:0]    sum;
  logic [RATE_MAG_W-1:0]  q_nxt;
  logic [RATE_MAG_W-1:0]  q1_r;
  logic [RATE_MAG_W-1:0]  q2_r;
  logic [RATE_MAG_W-1:0]  q3_r;
  logic signed [RATE_W-1:0] result_r;

  assign mag = raw[RAW_W-1] ? MAG_W'(-raw) : MAG_W'(raw);

  // Divisor is a power of two: add half, then shift
  assign sh    = gyr_shift(gyro_range);
  assign sum   = p0_r + (RATE_P_W'(1) << (sh - SH_W'(1)));
  assign q_nxt = RATE_MAG_W'(sum >> sh);

  always_ff @(posedge clk) begin
    // stage 0: scale by 100000
    if (ctl.load[0]) begin
      p0_r     <= RATE_P_W'(mag) * RATE_P_W'(RATE_MUL);
      neg_r[0] <= raw[RAW_W-1];
    end
    // stage 1: rounded divide
    if (ctl.load[1]) begin
      q1_r     <= q_nxt;
      neg_r[1] <= neg_r[0];
    end
    // stages 2 and 3: delay to line up with the accel lanes
    if (ctl.load[2]) begin
      q2_r     <= q1_r;
      neg_r[2] <= neg_r[1];
    end
    if (ctl.load[3]) begin
      q3_r     <= q2_r;
      neg_r[3] <= neg_r[2];
    end
    // stage 4: sign
    if (ctl.load[4]) begin
      result_r <= neg_r[3] ? -$signed(RATE_W'(q3_r)) : $signed(RATE_W'(q3_r));
    end
  end

  assign result = result_r;

endmodule

// ----- rtl/core/imu_raw_to_units_converter_top.sv -----
// Top level of the IMU raw-to-units converter: config registers, three accel
// and three rate lanes, and the pipeline control. Depends on imuc_pkg and all lane modules.
//
// Usage:
//   Input channel (in_*): one raw sample per beat, six signed 16-bit axes.
//   Output channel (out_*): one converted sample per beat; accel in
//   hundredths of m/s^2, angular rate in hundredths of deg/s.
//   A beat moves on a rising edge with valid high and stall low.
//   cfg_*: write enable, register index (0 accel range, 1 gyro range), data.
//   Write only while no sample is in flight.
// Depth: five register stages lie between the input beat and out_valid.
// Throughput: one sample per cycle while out_stall is low; the six lanes work in
//   parallel, and the depth is set by the two reciprocal multiplies of the accel path.
// Stall: out_stall holds the output register; empty stages still fill, and
//   in_stall rises only once every stage holds a sample.
// Reset (rst_n low, synchronous): pipeline empties, accel range returns to
//   8 g and gyro range to 500 dps.
module imu_raw_to_units_converter_top import imuc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [RAW_W-1:0]  in_raw_accel_x,
  input  logic signed [RAW_W-1:0]  in_raw_accel_y,
  input  logic signed [RAW_W-1:0]  in_raw_accel_z,
  input  logic signed [RAW_W-1:0]  in_raw_rate_x,
  input  logic signed [RAW_W-1:0]  in_raw_rate_y,
  input  logic signed [RAW_W-1:0]  in_raw_rate_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  out_accel_x_centi_ms2,
  output logic signed [ACC_W-1:0]  out_accel_y_centi_ms2,
  output logic signed [ACC_W-1:0]  out_accel_z_centi_ms2,
  output logic signed [RATE_W-1:0] out_rate_x_centi_dps,
  output logic signed [RATE_W-1:0] out_rate_y_centi_dps,
  output logic signed [RATE_W-1:0] out_rate_z_centi_dps
);

  logic [1:0] accel_range_r;
  logic [2:0] gyro_range_r;
  imuc_ctl_t  ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r <= 2'd2;
      gyro_range_r  <= 3'd2;
    end else if (cfg_write) begin
      if (cfg_index == CFG_ACCEL_RANGE) begin
        accel_range_r <= cfg_data[1:0];
      end
      if (cfg_index == CFG_GYRO_RANGE) begin
        gyro_range_r <= cfg_data[2:0];
      end
    end
  end

  // Pipeline control
  imuc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Accelerometer lanes
  imuc_accel_lane u_acc_x (
    .clk (clk), .ctl (ctl), .accel_range (accel_range_r),
    .raw (in_raw_accel_x), .result (out_accel_x_centi_ms2)
  );
  imuc_accel_lane u_acc_y (
    .clk (clk), .ctl (ctl), .accel_range (accel_range_r),
    .raw (in_raw_accel_y), .result (out_accel_y_centi_ms2)
  );
  imuc_accel_lane u_acc_z (
    .clk (clk), .ctl (ctl), .accel_range (accel_range_r),
    .raw (in_raw_accel_z), .result (out_accel_z_centi_ms2)
  );

  // Gyroscope lanes
  imuc_rate_lane u_rate_x (
    .clk (clk), .ctl (ctl), .gyro_range (gyro_range_r),
    .raw (in_raw_rate_x), .result (out_rate_x_centi_dps)
  );
  imuc_rate_lane u_rate_y (
    .clk (clk), .ctl (ctl), .gyro_range (gyro_range_r),
    .raw (in_raw_rate_y), .result (out_rate_y_centi_dps)
  );
  imuc_rate_lane u_rate_z (
    .clk (clk), .ctl (ctl), .gyro_range (gyro_range_r),
    .raw (in_raw_rate_z), .result (out_rate_z_centi_dps)
  );

endmodule

// ----- dv/imu_raw_to_units_converter_top_tb.sv -----
// Self-checking testbench for imu_raw_to_units_converter_top: directed table, then
// random phases under several range settings. Depends on imuc_pkg and the RTL.
`timescale 1ns / 100ps

module imu_raw_to_units_converter_top_tb;
  import imuc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 125;
  localparam int PHASE_COUNT  = 8;
  localparam int DIR_ROWS     = 16;

  // One raw sample and one converted sample, axis 0 is x
  typedef struct packed {
    logic [2:0][RAW_W-1:0] acc;
    logic [2:0][RAW_W-1:0] rate;
  } raw_sample_t;

  typedef struct packed {
    logic [2:0][ACC_W-1:0]  acc;
    logic [2:0][RATE_W-1:0] rate;
  } units_t;

  // Directed row: range writes, raw axes, and a typed result where known
  typedef struct {
    logic [CFG_W-1:0] acc_wr;
    logic [CFG_W-1:0] gyr_wr;
    bit               typed;
    int               ax, ay, az, rx, ry, rz;
    int               eax, eay, eaz, erx, ery, erz;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset ranges: zero input, extremes, rounding points
    '{3'd2, 3'd2, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{3'd2, 3'd2, 1'b0, 32767, -32768, -1, 1, -32768, 32767, 0, 0, 0, 0, 0, 0},
    '{3'd2, 3'd2, 1'b0, 8, -9, 500, -21846, 21845, 3, 0, 0, 0, 0, 0, 0},
    // 16 g / 2000 dps: largest magnitudes of both outputs
    '{3'd3, 3'd0, 1'b1, 32767, -32768, 0, 32767, -32768, 0,
      15681, -15682, 0, 199994, -200000, 0},
    '{3'd3, 3'd0, 1'b0, -1, 1, -2, -1, 1, 2, 0, 0, 0, 0, 0, 0},
    '{3'd3, 3'd0, 1'b0, 1000, -1000, 16384, 164, -164, -16384, 0, 0, 0, 0, 0, 0},
    '{3'd0, 3'd1, 1'b0, 32767, -32768, 8, -32768, 32767, -1, 0, 0, 0, 0, 0, 0},
    '{3'd0, 3'd1, 1'b0, 9, -8, -9, 16, -16, 327, 0, 0, 0, 0, 0, 0},
    '{3'd1, 3'd3, 1'b0, 32767, -32768, -1, 32767, -32768, 1, 0, 0, 0, 0, 0, 0},
    '{3'd1, 3'd3, 1'b0, 4, -4, -5, 655, -655, 1311, 0, 0, 0, 0, 0, 0},
    // accel write with the unused top bit set
    '{3'd4, 3'd4, 1'b0, 32767, -32768, 1, 32767, -32768, -1, 0, 0, 0, 0, 0, 0},
    '{3'd4, 3'd4, 1'b0, -7, 7, 123, 1, -2, 3, 0, 0, 0, 0, 0, 0},
    // unused gyro codes fall back to 500 dps; the last row returns to 2000 dps
    '{3'd2, 3'd5, 1'b0, 32767, -32768, 0, 32767, -32768, -1, 0, 0, 0, 0, 0, 0},
    '{3'd3, 3'd6, 1'b0, -32768, 32767, -1, -32768, 32767, 1, 0, 0, 0, 0, 0, 0},
    '{3'd5, 3'd7, 1'b0, 1, -1, 32767, 1, -1, -32768, 0, 0, 0, 0, 0, 0},
    '{3'd7, 3'd0, 1'b0, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_write = 1'b0;
  logic [0:0]               cfg_index = CFG_ACCEL_RANGE;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [RAW_W-1:0]  in_raw_accel_x = '0;
  logic signed [RAW_W-1:0]  in_raw_accel_y = '0;
  logic signed [RAW_W-1:0]  in_raw_accel_z = '0;
  logic signed [RAW_W-1:0]  in_raw_rate_x = '0;
  logic signed [RAW_W-1:0]  in_raw_rate_y = '0;
  logic signed [RAW_W-1:0]  in_raw_rate_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ACC_W-1:0]  out_accel_x_centi_ms2;
  logic signed [ACC_W-1:0]  out_accel_y_centi_ms2;
  logic signed [ACC_W-1:0]  out_accel_z_centi_ms2;
  logic signed [RATE_W-1:0] out_rate_x_centi_dps;
  logic signed [RATE_W-1:0] out_rate_y_centi_dps;
  logic signed [RATE_W-1:0] out_rate_z_centi_dps;

  // Mirror of the range registers and the queue of converted samples due
  logic [1:0] acc_code = 2'd2;
  logic [2:0] gyr_code = 3'd2;
  units_t     pending_units [$];
  int         err_count = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;

  // Receiver stall pattern state
  int         stall_mode = 0;
  int         stall_run = 0;
  int         stall_phase = 0;

  imu_raw_to_units_converter_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_raw_accel_x        (in_raw_accel_x),
    .in_raw_accel_y        (in_raw_accel_y),
    .in_raw_accel_z        (in_raw_accel_z),
    .in_raw_rate_x         (in_raw_rate_x),
    .in_raw_rate_y         (in_raw_rate_y),
    .in_raw_rate_z         (in_raw_rate_z),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accel_x_centi_ms2 (out_accel_x_centi_ms2),
    .out_accel_y_centi_ms2 (out_accel_y_centi_ms2),
    .out_accel_z_centi_ms2 (out_accel_z_centi_ms2),
    .out_rate_x_centi_dps  (out_rate_x_centi_dps),
    .out_rate_y_centi_dps  (out_rate_y_centi_dps),
    .out_rate_z_centi_dps  (out_rate_z_centi_dps)
  );

  always #5 clk = ~clk;

  // Predicted conversion of one sample under the given range codes
  function automatic units_t to_units(input raw_sample_t s, input logic [1:0] acode,
                                      input logic [2:0] gcode);
    units_t res;
    longint scale, divisor, r, mg, v;
    case (acode)
      2'd0:    scale = 61;
      2'd1:    scale = 122;
      2'd2:    scale = 244;
      default: scale = 488;
    endcase
    case (gcode)
      3'd0:    divisor = 16384;
      3'd1:    divisor = 32768;
      3'd3:    divisor = 131072;
      3'd4:    divisor = 262144;
      default: divisor = 65536;
    endcase
    for (int i = 0; i < 3; i++) begin
      // mg rounded half away from zero, then scaled to cm/s^2 the same way
      r  = longint'($signed(s.acc[i]));
      mg = (r * scale + ((r >= 0) ? 500 : -500)) / 1000;
      v  = (mg * 980665 + ((mg >= 0) ? 500000 : -500000)) / 1000000;
      res.acc[i] = v[ACC_W-1:0];
      // rate: offset by half the divisor away from zero, truncating divide
      r = longint'($signed(s.rate[i]));
      v = (r * 100000 + ((r >= 0) ? divisor / 2 : -(divisor / 2))) / divisor;
      res.rate[i] = v[RATE_W-1:0];
    end
    return res;
  endfunction

  // Raw axis value: extremes, zero, small signed values, or anything
  function automatic logic [RAW_W-1:0] pick_raw();
    logic [RAW_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3, 4: begin
        v = RAW_W'($urandom_range(0, 600));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = RAW_W'($urandom);
    endcase
    return v;
  endfunction

  // Drive one sample beat, wait for it to be taken, queue its expected result
  task automatic send_sample(input raw_sample_t s, input bit typed, input units_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_raw_accel_x <= s.acc[0];
    in_raw_accel_y <= s.acc[1];
    in_raw_accel_z <= s.acc[2];
    in_raw_rate_x  <= s.rate[0];
    in_raw_rate_y  <= s.rate[1];
    in_raw_rate_z  <= s.rate[2];
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_units.push_back(typed ? want : to_units(s, acc_code, gyr_code));
  endtask

  // Let the pipeline empty, then write both range registers
  task automatic set_ranges(input logic [CFG_W-1:0] acc_wr, input logic [CFG_W-1:0] gyr_wr);
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ACCEL_RANGE;
    cfg_data  <= acc_wr;
    @(posedge clk);
    cfg_index <= CFG_GYRO_RANGE;
    cfg_data  <= gyr_wr;
    @(posedge clk);
    cfg_write <= 1'b0;
    acc_code  = acc_wr[1:0];
    gyr_code  = gyr_wr;
  endtask

  // Receiver stall: free-running, bursts of random stall, periodic, heavy
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      2:       out_stall <= (stall_phase % 5 == 4);
      default: out_stall <= ($urandom_range(0, 99) < 80);
    endcase
  end

  // Result checker and idle watchdog
  always @(posedge clk) begin
    units_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.acc[0]  = out_accel_x_centi_ms2;
        got.acc[1]  = out_accel_y_centi_ms2;
        got.acc[2]  = out_accel_z_centi_ms2;
        got.rate[0] = out_rate_x_centi_dps;
        got.rate[1] = out_rate_y_centi_dps;
        got.rate[2] = out_rate_z_centi_dps;
        if (pending_units.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual %h", $time, got);
          err_count++;
        end else begin
          want = pending_units.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got.acc[i] !== want.acc[i]) begin
              $display("%0t: accel axis %0d mismatch, expected %0d, actual %0d", $time, i,
                       $signed(want.acc[i]), $signed(got.acc[i]));
              err_count++;
            end
            if (got.rate[i] !== want.rate[i]) begin
              $display("%0t: rate axis %0d mismatch, expected %0d, actual %0d", $time, i,
                       $signed(want.rate[i]), $signed(got.rate[i]));
              err_count++;
            end
          end
        end
      end
      // no beat on either channel for too long means a hang
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("imu_raw_to_units_converter_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin
    raw_sample_t s;
    units_t      want;
    logic [CFG_W-1:0] acc_wr, gyr_wr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 0 || dir_tab[i].acc_wr != dir_tab[i-1].acc_wr ||
          dir_tab[i].gyr_wr != dir_tab[i-1].gyr_wr)
        set_ranges(dir_tab[i].acc_wr, dir_tab[i].gyr_wr);
      s.acc[0]     = RAW_W'(dir_tab[i].ax);
      s.acc[1]     = RAW_W'(dir_tab[i].ay);
      s.acc[2]     = RAW_W'(dir_tab[i].az);
      s.rate[0]    = RAW_W'(dir_tab[i].rx);
      s.rate[1]    = RAW_W'(dir_tab[i].ry);
      s.rate[2]    = RAW_W'(dir_tab[i].rz);
      want.acc[0]  = ACC_W'(dir_tab[i].eax);
      want.acc[1]  = ACC_W'(dir_tab[i].eay);
      want.acc[2]  = ACC_W'(dir_tab[i].eaz);
      want.rate[0] = RATE_W'(dir_tab[i].erx);
      want.rate[1] = RATE_W'(dir_tab[i].ery);
      want.rate[2] = RATE_W'(dir_tab[i].erz);
      send_sample(s, dir_tab[i].typed, want);
    end

    // first phases pin the range extremes, the rest are random codes
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin acc_wr = 3'd0; gyr_wr = 3'd0; end
        1: begin acc_wr = 3'd3; gyr_wr = 3'd4; end
        2: begin acc_wr = 3'd3; gyr_wr = 3'd0; end
        3: begin acc_wr = 3'd0; gyr_wr = 3'd4; end
        default: begin
          acc_wr = CFG_W'($urandom_range(0, 7));
          gyr_wr = CFG_W'($urandom_range(0, 7));
        end
      endcase
      set_ranges(acc_wr, gyr_wr);
      repeat (PHASE_ITEMS) begin
        for (int k = 0; k < 3; k++) begin
          s.acc[k]  = pick_raw();
          s.rate[k] = pick_raw();
        end
        send_sample(s, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (NSTAGE * 4) @(posedge clk);
    if (err_count == 0 && pending_units.size() == 0)
      $display("imu_raw_to_units_converter_top regression: pass");
    else
      $display("imu_raw_to_units_converter_top regression: fail");
    $finish;
  end

endmodule
